>>> rtl/core/text_line_folder_assert.svh
// Assertion macros used by the line folder back end.
`ifndef TEXT_LINE_FOLDER_ASSERT_SVH
`define TEXT_LINE_FOLDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define TLF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TLF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/tlf_pkg.sv
// Package with the types, constants and codes of the line folder.
`timescale 1ns / 1ps
package tlf_pkg;

    localparam int LINE_WIDTH_DEF = 32;
    localparam int TAB_STOP_DEF   = 8;
    localparam int Q_DEPTH        = 2;

    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_NL  = 8'd10;
    localparam logic [7:0] CH_SP  = 8'd32;

    typedef enum logic [1:0] {
        K_CHAR,
        K_TAB,
        K_NL
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAB,
        S_EMIT_RD,
        S_EMIT_WAIT,
        S_EMIT_NL
    } t_back_state;

endpackage

>>> rtl/core/tlf_if.sv
// Stream interfaces for the character word in and the result word out.
`timescale 1ns / 1ps
interface tlf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;

    modport source (output valid, output in_char, input ready);
    modport sink   (input valid, input in_char, output ready);
endinterface

interface tlf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

>>> rtl/core/text_line_folder.sv
// Top level of the line folder: front end, command queue and back end.
`timescale 1ns / 1ps
//
//  Channel   Direction  Payload                      Word meaning
//  i_in      in         in_char[7:0]                 one input character
//  o_out     out        out_char[7:0], last_of_run   one emitted character
//
// A plain character is stored as it is taken; a tab writes one to TAB_STOP spaces,
// one at a time, up to the next tab stop.
// Emitting a line alternates a read and a wait per character, set by the single read
// port of the line store and its registered read data feeding the output register.
// The front end takes a word whenever the two-entry command queue has room, so input
// keeps flowing while the back end waits on a stalled output, until the queue fills.
// Reset clears the column, the tab phase and the handshake state; the line store has
// no clearing pass and holds whatever it held until written.
//
// The line store is a circular buffer: after a fold the leftover characters stay in
// place and the head pointer moves past the emitted part instead of copying them.
// The position of the newest blank beyond column zero is tracked as characters are
// written, so a fold finds its cut point at once instead of scanning the store.
// Each input character is classified up front as a tab, a newline or a character to
// store, and the back end carries the commands out one at a time in order.
module text_line_folder import tlf_pkg::*; #(
    parameter int LINE_WIDTH = LINE_WIDTH_DEF,
    parameter int TAB_STOP   = TAB_STOP_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tlf_in_if.sink    i_in,
    tlf_out_if.source o_out
);

    // Commands leave the front end already classified, so the back end never looks
    // at raw character codes except to spot a blank.
    logic      w_push;
    logic      w_q_full;
    logic      w_pop;
    t_cmd      w_cmd;
    t_q_status w_status;

    tlf_front u_front (
        .i_in     (i_in),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_cmd    (w_cmd)
    );

    // The queue decouples input acceptance from the multi-cycle work in the back end.
    tlf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_cmd),
        .o_full   (w_q_full),
        .i_pop    (w_pop),
        .o_status (w_status)
    );

    // The back end owns the line store, the column and the output register.
    tlf_back #(
        .LINE_WIDTH (LINE_WIDTH),
        .TAB_STOP   (TAB_STOP)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

endmodule

>>> rtl/core/tlf_front.sv
// Front end: accepts input words and classifies each character into a command.
`timescale 1ns / 1ps
module tlf_front import tlf_pkg::*; (
    tlf_in_if.sink i_in,
    input  logic   i_q_full,
    output logic   o_push,
    output t_cmd   o_cmd
);

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    always_comb begin
        o_cmd.ch = i_in.in_char;
        case (i_in.in_char)
            CH_TAB:  o_cmd.kind = K_TAB;
            CH_NL:   o_cmd.kind = K_NL;
            default: o_cmd.kind = K_CHAR;
        endcase
    end

endmodule

>>> rtl/core/tlf_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module tlf_queue import tlf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    output logic      o_full,
    input  logic      i_pop,
    output t_q_status o_status
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_buf [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // Reported full while reset is held so that no word is taken and then dropped.
    assign o_full          = (r_cnt == CNT_W'(Q_DEPTH)) || !i_rst_n;
    assign o_status.valid  = (r_cnt != '0);
    assign o_status.cmd    = r_buf[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> rtl/core/tlf_back.sv
// Back end: line store, tab expansion, fold cut and line emission.
`timescale 1ns / 1ps
`include "text_line_folder_assert.svh"
module tlf_back import tlf_pkg::*; #(
    parameter int LINE_WIDTH = LINE_WIDTH_DEF,
    parameter int TAB_STOP   = TAB_STOP_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_status i_status,
    output logic      o_pop,
    tlf_out_if.source o_out
);

    localparam int IDX_W = $clog2(LINE_WIDTH);
    localparam int COL_W = $clog2(LINE_WIDTH + 1);
    localparam int PH_W  = $clog2(TAB_STOP + 1);
    localparam int W_MOD = LINE_WIDTH % TAB_STOP;

    t_back_state      r_state, n_state;
    logic [IDX_W-1:0] r_head, n_head;
    logic [COL_W-1:0] r_col, n_col;
    logic [PH_W-1:0]  r_phase, n_phase;
    logic             r_blank_ok, n_blank_ok;
    logic [COL_W-1:0] r_blank_col, n_blank_col;
    logic [COL_W-1:0] r_emit_idx, n_emit_idx;
    logic [COL_W-1:0] r_emit_cnt, n_emit_cnt;
    logic [PH_W-1:0]  r_emit_ph, n_emit_ph;
    logic             r_emit_fold, n_emit_fold;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_char, n_out_char;
    logic             r_out_last, n_out_last;
    logic [7:0]       r_rd_data;
    logic [7:0]       r_mem [LINE_WIDTH];

    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_addr;
    logic [7:0]       w_wr_data;
    logic             w_rd_en;
    logic [IDX_W-1:0] w_rd_addr;
    logic             w_out_free;
    logic [COL_W-1:0] w_col_inc;
    logic             w_col_full;
    logic             w_ph_wrap;
    logic [PH_W-1:0]  w_ph_inc;
    logic [PH_W-1:0]  w_eph_inc;
    logic             w_sp_here;
    logic [COL_W-1:0] w_cut;
    logic [PH_W:0]    w_fold_ph;

    // Logical column to physical slot of the circular line store.
    function automatic logic [IDX_W-1:0] f_phys(input logic [IDX_W-1:0] base,
                                                input logic [COL_W-1:0] ofs);
        logic [COL_W:0] s;
        s = (COL_W+1)'(base) + (COL_W+1)'(ofs);
        if (s >= (COL_W+1)'(LINE_WIDTH)) begin
            s = s - (COL_W+1)'(LINE_WIDTH);
        end
        return s[IDX_W-1:0];
    endfunction

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_col_inc  = r_col + COL_W'(1);
    assign w_col_full = (w_col_inc == COL_W'(LINE_WIDTH));
    assign w_ph_wrap  = (r_phase == PH_W'(TAB_STOP - 1));
    assign w_ph_inc   = w_ph_wrap ? '0 : r_phase + PH_W'(1);
    assign w_eph_inc  = (r_emit_ph == PH_W'(TAB_STOP - 1)) ? '0 : r_emit_ph + PH_W'(1);
    assign w_sp_here  = (i_status.cmd.ch == CH_SP) && (r_col != '0);

    // The newest blank past column zero wins; without one the whole line goes.
    always_comb begin
        if (w_sp_here) begin
            w_cut = w_col_inc;
        end else if (r_blank_ok) begin
            w_cut = r_blank_col + COL_W'(1);
        end else begin
            w_cut = COL_W'(LINE_WIDTH);
        end
    end

    // Tab phase of the remainder after a fold, from the cut length modulo the stop.
    always_comb begin
        if ({1'b0, r_emit_ph} > (PH_W+1)'(W_MOD)) begin
            w_fold_ph = (PH_W+1)'(W_MOD) + (PH_W+1)'(TAB_STOP) - {1'b0, r_emit_ph};
        end else begin
            w_fold_ph = (PH_W+1)'(W_MOD) - {1'b0, r_emit_ph};
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_status.valid) begin
                    case (i_status.cmd.kind)
                        K_CHAR: if (w_col_full) n_state = S_EMIT_RD;
                        K_TAB:  n_state = S_TAB;
                        K_NL:   if (r_col != '0) n_state = S_EMIT_RD;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_TAB: begin
                if (w_col_full) begin
                    n_state = S_EMIT_RD;
                end else if (w_ph_wrap) begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT_RD: begin
                n_state = (r_emit_idx == r_emit_cnt) ? S_EMIT_NL : S_EMIT_WAIT;
            end
            S_EMIT_WAIT: if (w_out_free) n_state = S_EMIT_RD;
            S_EMIT_NL:   if (w_out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_head      = r_head;
        n_col       = r_col;
        n_phase     = r_phase;
        n_blank_ok  = r_blank_ok;
        n_blank_col = r_blank_col;
        n_emit_idx  = r_emit_idx;
        n_emit_cnt  = r_emit_cnt;
        n_emit_ph   = r_emit_ph;
        n_emit_fold = r_emit_fold;
        n_out_valid = w_out_free ? 1'b0 : r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        w_wr_en     = 1'b0;
        w_wr_addr   = f_phys(r_head, r_col);
        w_wr_data   = i_status.cmd.ch;
        w_rd_en     = 1'b0;
        w_rd_addr   = f_phys(r_head, r_emit_idx);
        o_pop       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_status.valid) begin
                    o_pop = 1'b1;
                    case (i_status.cmd.kind)
                        K_CHAR: begin
                            w_wr_en = 1'b1;
                            if (w_sp_here) begin
                                n_blank_ok  = 1'b1;
                                n_blank_col = r_col;
                            end
                            if (w_col_full) begin
                                n_emit_cnt  = w_cut;
                                n_emit_idx  = '0;
                                n_emit_ph   = '0;
                                n_emit_fold = 1'b1;
                            end else begin
                                n_col   = w_col_inc;
                                n_phase = w_ph_inc;
                            end
                        end
                        K_NL: begin
                            if (r_col != '0) begin
                                n_emit_cnt  = r_col;
                                n_emit_idx  = '0;
                                n_emit_ph   = '0;
                                n_emit_fold = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_TAB: begin
                w_wr_en   = 1'b1;
                w_wr_data = CH_SP;
                if (r_col != '0) begin
                    n_blank_ok  = 1'b1;
                    n_blank_col = r_col;
                end
                if (w_col_full) begin
                    n_emit_cnt  = COL_W'(LINE_WIDTH);
                    n_emit_idx  = '0;
                    n_emit_ph   = '0;
                    n_emit_fold = 1'b0;
                end else begin
                    n_col   = w_col_inc;
                    n_phase = w_ph_inc;
                end
            end
            S_EMIT_RD: begin
                w_rd_en = (r_emit_idx != r_emit_cnt);
            end
            S_EMIT_WAIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = r_rd_data;
                    n_out_last  = 1'b0;
                    n_emit_idx  = r_emit_idx + COL_W'(1);
                    n_emit_ph   = w_eph_inc;
                end
            end
            S_EMIT_NL: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CH_NL;
                    n_out_last  = 1'b1;
                    n_head      = f_phys(r_head, r_emit_cnt);
                    n_blank_ok  = 1'b0;
                    if (r_emit_fold) begin
                        n_col   = COL_W'(LINE_WIDTH) - r_emit_cnt;
                        n_phase = w_fold_ph[PH_W-1:0];
                    end else begin
                        n_col   = '0;
                        n_phase = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_col       <= '0;
            r_phase     <= '0;
            r_blank_ok  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_col       <= n_col;
            r_phase     <= n_phase;
            r_blank_ok  <= n_blank_ok;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blank_col <= n_blank_col;
        r_emit_idx  <= n_emit_idx;
        r_emit_cnt  <= n_emit_cnt;
        r_emit_ph   <= n_emit_ph;
        r_emit_fold <= n_emit_fold;
        r_out_char  <= n_out_char;
        r_out_last  <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_char    = r_out_char;
    assign o_out.last_of_run = r_out_last;

    `TLF_ASSERT_NOW(a_col_below_width, i_clk, i_rst_n, 1'b1, r_col < COL_W'(LINE_WIDTH), "column reached the line width")
    `TLF_ASSERT_NOW(a_last_is_newline, i_clk, i_rst_n, r_out_valid && r_out_last, r_out_char == CH_NL, "run closed without a newline")
    `TLF_ASSERT_NOW(a_emit_in_range, i_clk, i_rst_n, (r_state == S_EMIT_RD) || (r_state == S_EMIT_WAIT), r_emit_idx <= r_emit_cnt, "emit index ran past the count")
    `TLF_ASSERT_NEXT(a_nl_ends_emit, i_clk, i_rst_n, (r_state == S_EMIT_NL) && w_out_free, r_out_valid && r_out_last && (r_state == S_IDLE), "newline did not close the emission")

endmodule
